FILE: hw/rtl/ptg_pkg.sv
// Shared types and constants of the pixel-to-glyph downsampler.
// No dependencies; the divider, queue, front end, back end and top level refer to this package.
package ptg_pkg;

  localparam int DIM_W    = 13;          // holds a clamped size, 1..MAX_DIM
  localparam int REM_W    = 12;          // remainder of a size division
  localparam int POS_W    = 12;          // source row and column counters
  localparam int MAX_DIM  = 4096;
  localparam int MAX_SYM  = 16;
  localparam int IDX_W    = 4;           // symbol index
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW  = 2;
  localparam int FIFO_CW  = 3;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH    = 3'd0,
    REG_SRC_HEIGHT   = 3'd1,
    REG_OUT_WIDTH    = 3'd2,
    REG_OUT_HEIGHT   = 3'd3,
    REG_SYMBOL_COUNT = 3'd4,
    REG_SYMBOLS_LOW  = 3'd5,
    REG_SYMBOLS_HIGH = 3'd6,
    REG_PIXEL_FORMAT = 3'd7
  } cfg_reg_t;

  // Clamped geometry and the step sizes of the pick accumulators.
  typedef struct packed {
    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] sh;
    logic [DIM_W-1:0] ow;
    logic [DIM_W-1:0] oh;
    logic [DIM_W-1:0] col_quo;
    logic [REM_W-1:0] col_rem;
    logic [DIM_W-1:0] row_quo;
    logic [REM_W-1:0] row_rem;
  } geom_t;

  // One picked pixel with its channels expanded, as queued for the back end.
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       color_en;
    logic       eol;
    logic       eof;
  } pick_t;

endpackage

FILE: hw/rtl/ptg_pix_if.sv
// Input channel of the downsampler: one source pixel per item.
// Stands alone; used by the front end and the top level.
interface ptg_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan0;
  logic [7:0] chan1;
  logic [7:0] chan2;
  logic [7:0] chan3;

  modport source (output valid, chan0, chan1, chan2, chan3, input ready);
  modport sink   (input valid, chan0, chan1, chan2, chan3, output ready);
endinterface

FILE: hw/rtl/ptg_res_if.sv
// Result channel of the downsampler: one glyph with colour and line marks per item.
// Stands alone; used by the back end and the top level.
interface ptg_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] glyph;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       has_color;
  logic       end_of_line;
  logic       end_of_frame;

  modport source (output valid, glyph, red_out, green_out, blue_out, has_color,
                  end_of_line, end_of_frame, input ready);
  modport sink   (input valid, glyph, red_out, green_out, blue_out, has_color,
                  end_of_line, end_of_frame, output ready);
endinterface

FILE: hw/rtl/ptg_div.sv
// Restoring divider, one quotient bit a cycle, for the pick step sizes.
// Depends on ptg_pkg.
module ptg_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ptg_pkg::DIM_W-1:0] num,
  input  logic [ptg_pkg::DIM_W-1:0] den,
  output logic                      busy,
  output logic [ptg_pkg::DIM_W-1:0] quo,
  output logic [ptg_pkg::REM_W-1:0] rem
);

  logic [ptg_pkg::DIM_W-1:0] quo_r, quo_nxt;
  logic [ptg_pkg::REM_W-1:0] rem_r, rem_nxt;
  logic [3:0]                cnt_r, cnt_nxt;
  logic [ptg_pkg::DIM_W-1:0] trial;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r, quo_r[ptg_pkg::DIM_W-1]};
    if (start) begin
      quo_nxt = num;
      rem_nxt = '0;
      cnt_nxt = 4'(ptg_pkg::DIM_W);
    end else if (cnt_r != 4'd0) begin
      cnt_nxt = cnt_r - 4'd1;
      if (trial >= den) begin
        rem_nxt = ptg_pkg::REM_W'(trial - den);
        quo_nxt = {quo_r[ptg_pkg::DIM_W-2:0], 1'b1};
      end else begin
        rem_nxt = ptg_pkg::REM_W'(trial);
        quo_nxt = {quo_r[ptg_pkg::DIM_W-2:0], 1'b0};
      end
    end
  end

  // The reset values match the reset geometry, a one-by-one picture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quo_r <= ptg_pkg::DIM_W'(1);
      rem_r <= '0;
      cnt_r <= '0;
    end else begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign busy = (cnt_r != 4'd0);
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

FILE: hw/rtl/ptg_fifo.sv
// Short queue of picked pixels between the front end and the back end.
// Depends on ptg_pkg.
module ptg_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ptg_pkg::pick_t push_data,
  input  logic           pop,
  output ptg_pkg::pick_t head,
  output logic           empty,
  output logic           full
);

  ptg_pkg::pick_t              mem_r [ptg_pkg::FIFO_DEPTH];
  logic [ptg_pkg::FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [ptg_pkg::FIFO_CW-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + ptg_pkg::FIFO_CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - ptg_pkg::FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + ptg_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + ptg_pkg::FIFO_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == ptg_pkg::FIFO_CW'(ptg_pkg::FIFO_DEPTH));

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ptg_pkg::FIFO_CW'(ptg_pkg::FIFO_DEPTH))
    else $error("queue holds more items than it has entries");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && full |-> pop)
    else $error("item pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("item popped from an empty queue");
`endif

endmodule

FILE: hw/rtl/ptg_front.sv
// Front end: accepts source pixels, tracks the raster position and picks the
// nearest-neighbour pixels for the queue. Depends on ptg_pkg and ptg_pix_if.
module ptg_front (
  input  logic                  clk,
  input  logic                  rst_n,
  ptg_pix_if.sink               in_pix,
  input  ptg_pkg::geom_t        geom,
  input  logic [1:0]            chan_sel,
  input  logic                  color_en,
  input  logic                  pos_clear,
  input  logic                  hold,
  output logic                  push,
  output ptg_pkg::pick_t        item
);

  logic [ptg_pkg::POS_W-1:0] src_col_r, src_col_nxt, src_row_r, src_row_nxt;
  logic [ptg_pkg::DIM_W-1:0] out_col_r, out_col_nxt, out_row_r, out_row_nxt;
  logic [ptg_pkg::DIM_W-1:0] npc_r, npc_nxt, npr_r, npr_nxt;
  logic [ptg_pkg::REM_W-1:0] crem_r, crem_nxt, rrem_r, rrem_nxt;
  logic [ptg_pkg::DIM_W-1:0] csum, rsum;
  logic                      accept, row_picked, picked, eol, eof;

  assign in_pix.ready = !hold;
  assign accept       = in_pix.valid && !hold;

  assign row_picked = (ptg_pkg::DIM_W'(src_row_r) == npr_r) && (out_row_r < geom.oh);
  assign picked     = row_picked && (ptg_pkg::DIM_W'(src_col_r) == npc_r)
                      && (out_col_r < geom.ow);
  assign eol        = (out_col_r == geom.ow - ptg_pkg::DIM_W'(1));
  assign eof        = eol && (out_row_r == geom.oh - ptg_pkg::DIM_W'(1));

  // Channels absent from the pixel format repeat red; alpha defaults to opaque.
  always_comb begin
    item.r        = in_pix.chan0;
    item.g        = (chan_sel >= 2'd1) ? in_pix.chan1 : in_pix.chan0;
    item.b        = (chan_sel >= 2'd2) ? in_pix.chan2 : in_pix.chan0;
    item.a        = (chan_sel == 2'd3) ? in_pix.chan3 : 8'hFF;
    item.color_en = color_en;
    item.eol      = eol;
    item.eof      = eof;
  end

  assign push = accept && picked;

  always_comb begin
    src_col_nxt = src_col_r;
    src_row_nxt = src_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    npc_nxt     = npc_r;
    npr_nxt     = npr_r;
    crem_nxt    = crem_r;
    rrem_nxt    = rrem_r;
    csum        = ptg_pkg::DIM_W'(crem_r) + ptg_pkg::DIM_W'(geom.col_rem);
    rsum        = ptg_pkg::DIM_W'(rrem_r) + ptg_pkg::DIM_W'(geom.row_rem);
    if (pos_clear) begin
      src_col_nxt = '0;
      src_row_nxt = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      npc_nxt     = '0;
      npr_nxt     = '0;
      crem_nxt    = '0;
      rrem_nxt    = '0;
    end else if (accept) begin
      if (picked) begin
        out_col_nxt = out_col_r + ptg_pkg::DIM_W'(1);
        if (csum >= geom.ow) begin
          crem_nxt = ptg_pkg::REM_W'(csum - geom.ow);
          npc_nxt  = npc_r + geom.col_quo + ptg_pkg::DIM_W'(1);
        end else begin
          crem_nxt = ptg_pkg::REM_W'(csum);
          npc_nxt  = npc_r + geom.col_quo;
        end
      end
      if (ptg_pkg::DIM_W'(src_col_r) + ptg_pkg::DIM_W'(1) >= geom.sw) begin
        src_col_nxt = '0;
        out_col_nxt = '0;
        npc_nxt     = '0;
        crem_nxt    = '0;
        if (ptg_pkg::DIM_W'(src_row_r) + ptg_pkg::DIM_W'(1) >= geom.sh) begin
          // Last pixel of the frame: everything starts over.
          src_row_nxt = '0;
          out_row_nxt = '0;
          npr_nxt     = '0;
          rrem_nxt    = '0;
        end else begin
          src_row_nxt = src_row_r + ptg_pkg::POS_W'(1);
          if (row_picked) begin
            out_row_nxt = out_row_r + ptg_pkg::DIM_W'(1);
            if (rsum >= geom.oh) begin
              rrem_nxt = ptg_pkg::REM_W'(rsum - geom.oh);
              npr_nxt  = npr_r + geom.row_quo + ptg_pkg::DIM_W'(1);
            end else begin
              rrem_nxt = ptg_pkg::REM_W'(rsum);
              npr_nxt  = npr_r + geom.row_quo;
            end
          end
        end
      end else begin
        src_col_nxt = src_col_r + ptg_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r <= '0;
      src_row_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      npc_r     <= '0;
      npr_r     <= '0;
      crem_r    <= '0;
      rrem_r    <= '0;
    end else begin
      src_col_r <= src_col_nxt;
      src_row_r <= src_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      npc_r     <= npc_nxt;
      npr_r     <= npr_nxt;
      crem_r    <= crem_nxt;
      rrem_r    <= rrem_nxt;
    end
  end

`ifndef SYNTHESIS
  a_out_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_col_r <= geom.ow)
    else $error("more glyphs picked on a line than there are columns");
`endif

endmodule

FILE: hw/rtl/ptg_back.sv
// Back end: luminance, symbol quantisation, glyph lookup and premultiplied
// colour for each queued pixel. Depends on ptg_pkg and ptg_res_if.
module ptg_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ptg_pkg::pick_t            head,
  input  logic                      empty,
  output logic                      pop,
  input  logic [ptg_pkg::IDX_W-1:0] sym_max,
  input  logic [8*ptg_pkg::MAX_SYM-1:0] symbols,
  ptg_res_if.source                 out_res
);

  localparam logic [19:0] LumStep    = 20'd65025;   // 255 * 255
  localparam logic [7:0]  GlyphSpace = 8'h20;

  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = 17'(p) + 17'(p[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  logic        en;
  // stage 1: weighted sum of the colour channels
  logic        s1_valid_r;
  logic [23:0] s1_sum_r;
  logic [7:0]  s1_r_r, s1_g_r, s1_b_r, s1_a_r;
  logic        s1_col_r, s1_eol_r, s1_eof_r;
  // stage 2: alpha applied
  logic        s2_valid_r;
  logic [31:0] s2_sa_r;
  logic [15:0] s2_pr_r, s2_pg_r, s2_pb_r;
  logic        s2_az_r, s2_col_r, s2_eol_r, s2_eof_r;
  // stage 3: scaled to the symbol range
  logic        s3_valid_r;
  logic [19:0] s3_t_r;
  logic [7:0]  s3_ro_r, s3_go_r, s3_bo_r;
  logic        s3_az_r, s3_hc_r, s3_eol_r, s3_eof_r;
  // result register
  logic        out_valid_r;
  logic [7:0]  glyph_r, red_r, green_r, blue_r;
  logic        hc_r, eol_r, eof_r;

  logic [35:0]               scaled;
  logic [ptg_pkg::IDX_W-1:0] idx;
  logic [7:0]                glyph_nxt;

  assign en  = !out_valid_r || out_res.ready;
  assign pop = en && !empty;

  assign scaled = 36'(s2_sa_r) * 36'(sym_max);

  // The index is the number of whole 255*255 steps in the scaled luminance.
  always_comb begin
    idx = '0;
    for (int k = 1; k < ptg_pkg::MAX_SYM; k++) begin
      if (s3_t_r >= 20'(k * LumStep)) begin
        idx = ptg_pkg::IDX_W'(k);
      end
    end
    if (idx > sym_max) begin
      idx = sym_max;
    end
    glyph_nxt = s3_az_r ? GlyphSpace : symbols[{idx, 3'b000} +: 8];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sum_r <= 24'(16'd19595) * 24'(head.r) + 24'(16'd38470) * 24'(head.g)
                  + 24'(16'd7471) * 24'(head.b);
      s1_r_r   <= head.r;
      s1_g_r   <= head.g;
      s1_b_r   <= head.b;
      s1_a_r   <= head.a;
      s1_col_r <= head.color_en;
      s1_eol_r <= head.eol;
      s1_eof_r <= head.eof;

      s2_sa_r  <= 32'(s1_sum_r) * 32'(s1_a_r);
      s2_pr_r  <= 16'(s1_r_r) * 16'(s1_a_r);
      s2_pg_r  <= 16'(s1_g_r) * 16'(s1_a_r);
      s2_pb_r  <= 16'(s1_b_r) * 16'(s1_a_r);
      s2_az_r  <= (s1_a_r == 8'd0);
      s2_col_r <= s1_col_r;
      s2_eol_r <= s1_eol_r;
      s2_eof_r <= s1_eof_r;

      s3_t_r   <= scaled[35:16];
      s3_hc_r  <= s2_col_r && !s2_az_r;
      s3_ro_r  <= (s2_col_r && !s2_az_r) ? div255(s2_pr_r) : 8'd0;
      s3_go_r  <= (s2_col_r && !s2_az_r) ? div255(s2_pg_r) : 8'd0;
      s3_bo_r  <= (s2_col_r && !s2_az_r) ? div255(s2_pb_r) : 8'd0;
      s3_az_r  <= s2_az_r;
      s3_eol_r <= s2_eol_r;
      s3_eof_r <= s2_eof_r;

      glyph_r  <= glyph_nxt;
      red_r    <= s3_ro_r;
      green_r  <= s3_go_r;
      blue_r   <= s3_bo_r;
      hc_r     <= s3_hc_r;
      eol_r    <= s3_eol_r;
      eof_r    <= s3_eof_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= !empty;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.glyph        = glyph_r;
  assign out_res.red_out      = red_r;
  assign out_res.green_out    = green_r;
  assign out_res.blue_out     = blue_r;
  assign out_res.has_color    = hc_r;
  assign out_res.end_of_line  = eol_r;
  assign out_res.end_of_frame = eof_r;

`ifndef SYNTHESIS
  a_no_colour_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !hc_r |-> red_r == 8'd0 && green_r == 8'd0 && blue_r == 8'd0)
    else $error("colour given on a glyph without colour");
`endif

endmodule

FILE: hw/rtl/pixel_to_glyph_downsampler.sv
// Top level of the pixel-to-glyph downsampler: configuration registers, the
// step-size dividers, front end, queue and back end. Depends on all of hw/rtl.
//
// Source pixels are taken one per clock in raster order unless the queue is
// full or a division runs; only the pixels that nearest-neighbour downsampling
// picks give a result, through the back end's four-stage pipeline, which
// delivers one glyph per clock while the result side is ready. A four-entry
// queue between position tracking and the glyph pipeline lets the input keep
// flowing while the result side stalls, until it fills. A write to any of the
// four size registers restarts the frame and recomputes the column and row
// step sizes in bit-serial dividers; the input is held off until both finish.
module pixel_to_glyph_downsampler (
  input  logic        clk,
  input  logic        rst_n,
  ptg_pix_if.sink     in_pix,
  ptg_res_if.source   out_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [ptg_pkg::DIM_W-1:0] src_width_r, src_height_r, out_width_r, out_height_r;
  logic [4:0]                symbol_count_r;
  logic [63:0]               symbols_low_r, symbols_high_r;
  logic [2:0]                pixel_format_r;
  logic                      geom_wr, start_r;

  logic [ptg_pkg::DIM_W-1:0] sw, sh, ow, oh;
  logic [ptg_pkg::IDX_W-1:0] sym_max;
  logic                      col_busy, row_busy, hold;
  logic [ptg_pkg::DIM_W-1:0] col_quo, row_quo;
  logic [ptg_pkg::REM_W-1:0] col_rem, row_rem;
  ptg_pkg::geom_t            geom;

  ptg_pkg::pick_t            item, head;
  logic                      push, pop, empty, full;

  function automatic logic [ptg_pkg::DIM_W-1:0] clamp_dim(
    input logic [ptg_pkg::DIM_W-1:0] v);
    if (v == '0) begin
      return ptg_pkg::DIM_W'(1);
    end else if (v > ptg_pkg::DIM_W'(ptg_pkg::MAX_DIM)) begin
      return ptg_pkg::DIM_W'(ptg_pkg::MAX_DIM);
    end
    return v;
  endfunction

  assign geom_wr = cfg_we && (cfg_index == ptg_pkg::REG_SRC_WIDTH
                           || cfg_index == ptg_pkg::REG_SRC_HEIGHT
                           || cfg_index == ptg_pkg::REG_OUT_WIDTH
                           || cfg_index == ptg_pkg::REG_OUT_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r    <= ptg_pkg::DIM_W'(1);
      src_height_r   <= ptg_pkg::DIM_W'(1);
      out_width_r    <= ptg_pkg::DIM_W'(1);
      out_height_r   <= ptg_pkg::DIM_W'(1);
      symbol_count_r <= 5'd8;
      symbols_low_r  <= '0;
      symbols_high_r <= '0;
      pixel_format_r <= 3'd3;
      start_r        <= 1'b0;
    end else begin
      start_r <= geom_wr;
      if (cfg_we) begin
        case (cfg_index)
          ptg_pkg::REG_SRC_WIDTH:    src_width_r    <= cfg_wdata[ptg_pkg::DIM_W-1:0];
          ptg_pkg::REG_SRC_HEIGHT:   src_height_r   <= cfg_wdata[ptg_pkg::DIM_W-1:0];
          ptg_pkg::REG_OUT_WIDTH:    out_width_r    <= cfg_wdata[ptg_pkg::DIM_W-1:0];
          ptg_pkg::REG_OUT_HEIGHT:   out_height_r   <= cfg_wdata[ptg_pkg::DIM_W-1:0];
          ptg_pkg::REG_SYMBOL_COUNT: symbol_count_r <= cfg_wdata[4:0];
          ptg_pkg::REG_SYMBOLS_LOW:  symbols_low_r  <= cfg_wdata;
          ptg_pkg::REG_SYMBOLS_HIGH: symbols_high_r <= cfg_wdata;
          ptg_pkg::REG_PIXEL_FORMAT: pixel_format_r <= cfg_wdata[2:0];
          default: ;
        endcase
      end
    end
  end

  // The output grid never exceeds the source; symbol count is held to 1..16.
  always_comb begin
    sw = clamp_dim(src_width_r);
    sh = clamp_dim(src_height_r);
    ow = clamp_dim(out_width_r);
    oh = clamp_dim(out_height_r);
    if (ow > sw) begin
      ow = sw;
    end
    if (oh > sh) begin
      oh = sh;
    end
    if (symbol_count_r == 5'd0) begin
      sym_max = '0;
    end else if (symbol_count_r > 5'(ptg_pkg::MAX_SYM)) begin
      sym_max = ptg_pkg::IDX_W'(ptg_pkg::MAX_SYM - 1);
    end else begin
      sym_max = ptg_pkg::IDX_W'(symbol_count_r - 5'd1);
    end
  end

  ptg_div u_col_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .num   (sw),
    .den   (ow),
    .busy  (col_busy),
    .quo   (col_quo),
    .rem   (col_rem)
  );

  ptg_div u_row_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .num   (sh),
    .den   (oh),
    .busy  (row_busy),
    .quo   (row_quo),
    .rem   (row_rem)
  );

  always_comb begin
    geom.sw      = sw;
    geom.sh      = sh;
    geom.ow      = ow;
    geom.oh      = oh;
    geom.col_quo = col_quo;
    geom.col_rem = col_rem;
    geom.row_quo = row_quo;
    geom.row_rem = row_rem;
  end

  assign hold = full || start_r || col_busy || row_busy;

  ptg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .geom      (geom),
    .chan_sel  (pixel_format_r[1:0]),
    .color_en  (pixel_format_r[2]),
    .pos_clear (geom_wr),
    .hold      (hold),
    .push      (push),
    .item      (item)
  );

  ptg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (item),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  ptg_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .empty   (empty),
    .pop     (pop),
    .sym_max (sym_max),
    .symbols ({symbols_high_r, symbols_low_r}),
    .out_res (out_res)
  );

`ifndef SYNTHESIS
  a_hold_after_resize: assert property (@(posedge clk) disable iff (!rst_n)
    geom_wr |=> !in_pix.ready)
    else $error("input taken while the step sizes are being recomputed");
`endif

endmodule
